>>> src/sips_pkg.sv
package sips_pkg;

   localparam int PW_W       = 16;
   localparam int SPLIT_W    = 7;
   localparam int MODE_W     = 2;
   localparam int CYL_W      = 4;
   localparam int LAYOUT_W   = 2;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 16;

   // shared mul/div unit: 26-bit operand times 16-bit operand, 42-bit quotient
   localparam int OPA_W = 26;
   localparam int OPB_W = 16;
   localparam int ACC_W = OPA_W + OPB_W;
   localparam int CNT_W = 6;

   localparam int OUT_CH = 8;
   localparam int REQ_W  = 40;
   localparam int RSP_W  = 136;
   localparam int ACTIVE_BIT = OUT_CH * PW_W;

   localparam logic [PW_W-1:0]    MAX_PW  = 16'hFFFF;
   localparam logic [SPLIT_W-1:0] PCT     = 7'd100;
   localparam logic [OPB_W-1:0]   PCT_DIV = 16'd100;

   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TABLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AUTO  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FULL  = 2'd3;

   localparam logic [LAYOUT_W-1:0] LAYOUT_SEMI = 2'd1;
   localparam logic [LAYOUT_W-1:0] LAYOUT_SEQ  = 2'd2;

   localparam logic [CFG_IDX_W-1:0] REG_STAGING_MODE    = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME       = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_MULT    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_SECONDARY_MULT  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_CYLINDER_COUNT  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_INJECTOR_LAYOUT = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_BODY   = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT    = 3'd7;

endpackage

>>> src/staged_injector_pulse_split.sv
// channel | direction | payload
// req     | in        | tdata[15:0] desired_pw, [31:16] pw_limit, [38:32] stage_split
// rsp     | out       | tdata[16*i+15:16*i] channel(i+1)_pw, [128] staging_active
// csr     | in        | csr_index register number, csr_data value (low bits used)
//
// Every product goes through one shift-add multiplier feeding a restoring
// divider, one operation at a time. Table mode runs four operations,
// automatic mode one or two; unstaged items and mode 3 skip the datapath
// and go straight to the wrap-up state.
// Reset is synchronous: control and configuration registers take their defaults, channel widths clear.
// req_tready is high only while the sequencer is idle; a finished item waits
// for the output register to free up before the channel widths are updated.
module staged_injector_pulse_split
   import sips_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // desired_pw, pw_limit, stage_split
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // channel1_pw .. channel8_pw, staging_active
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_SCALED,
      OP_SEC_SCALED,
      OP_SEC_TABLE,
      OP_PRI_TABLE,
      OP_SEC_AUTO
   } op_type;

   localparam logic [CYL_W-1:0] CH_LIM = CYL_W'(CHANNELS);
   localparam logic [127:0] HI_MASK = ~((128'(1) << (PW_W * CHANNELS)) - 128'(1));

   // configuration
   logic [MODE_W-1:0]   mode_ff;
   logic [PW_W-1:0]     open_ff;
   logic [PW_W-1:0]     pmult_ff;
   logic [PW_W-1:0]     smult_ff;
   logic [CYL_W-1:0]    cyl_ff;
   logic [LAYOUT_W-1:0] layout_ff;
   logic                tb_ff;
   logic [CYL_W-1:0]    outcnt_ff;

   // sequencer and datapath
   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [PW_W-1:0]     desired_ff, desired_in;
   logic [PW_W-1:0]     limit_ff, limit_in;
   logic [SPLIT_W-1:0]  split_ff, split_in;
   logic                staged_ff, staged_in;
   logic                active_ff, active_in;
   logic [OPA_W-1:0]    scaled_ff, scaled_in;
   logic [PW_W-1:0]     pri_ff, pri_in;
   logic [PW_W-1:0]     sec_ff, sec_in;
   logic [OPA_W-1:0]    a_ff, a_in;
   logic [OPB_W-1:0]    b_ff, b_in;
   logic [OPB_W-1:0]    d_ff, d_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [OPB_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PW_W-1:0]     chan_ff [CHANNELS];
   logic [PW_W-1:0]     chan_in [CHANNELS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   // request fields
   logic [PW_W-1:0]     req_desired;
   logic [PW_W-1:0]     req_limit;
   logic [SPLIT_W-1:0]  req_split;
   logic                req_stage;

   // unit internals
   logic [OPB_W:0]      trial;
   logic                qbit;
   logic [ACC_W-1:0]    quot;
   logic [PW_W-1:0]     quot_sat;
   logic [OPA_W-1:0]    extra;

   // channel assignment
   logic [OUT_CH-1:0]   wr_p, wr_s;
   logic                seq, semi;
   logic [PW_W:0]       p_sum, s_sum;
   logic [PW_W-1:0]     p16, s16;

   assign req_desired = req_tdata[15:0];
   assign req_limit   = req_tdata[31:16];
   assign req_split   = req_tdata[38:32];
   assign req_stage   = (mode_ff != MODE_OFF) && ((cyl_ff <= CH_LIM) || tb_ff)
                        && (req_desired > open_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // one restoring division step
   assign trial    = {rem_ff, acc_ff[ACC_W-1]};
   assign qbit     = (trial >= {1'b0, d_ff});
   assign quot     = {acc_ff[ACC_W-2:0], qbit};
   assign quot_sat = (|quot[ACC_W-1:PW_W]) ? MAX_PW : quot[PW_W-1:0];
   assign extra    = quot[OPA_W-1:0] - OPA_W'(limit_ff);

   assign seq  = (layout_ff == LAYOUT_SEQ);
   assign semi = (layout_ff == LAYOUT_SEMI);

   always_comb begin
      wr_p = '0;
      wr_s = '0;
      unique case (cyl_ff)
         4'd1: begin
            wr_p = 8'b0000_0001;
            wr_s = 8'b0000_0010;
         end
         4'd3: begin
            wr_p = 8'b0000_0111;
            wr_s = (CHANNELS >= 6) ? 8'b0011_1000 : 8'b0000_1000;
         end
         4'd4: begin
            if (seq || semi) begin
               if (CHANNELS >= 8) begin
                  wr_p = 8'b0000_1111;
                  wr_s = 8'b1111_0000;
               end else if (CHANNELS >= 5) begin
                  wr_s = 8'b0001_0000;
               end
            end else begin
               wr_p = 8'b0000_0011;
               wr_s = 8'b0000_1100;
            end
         end
         4'd5: begin
            wr_p = 8'b0001_1111;
            wr_s = 8'b0010_0000;
         end
         4'd6: begin
            wr_p = 8'b0000_0111;
            if (CHANNELS >= 6) begin
               if (!seq) begin
                  wr_s = 8'b0011_1000;
               end else if (CHANNELS >= 8) begin
                  wr_p = 8'b0011_1111;
                  wr_s = 8'b1100_0000;
               end
            end
         end
         4'd8: begin
            wr_p = 8'b0000_1111;
            if (CHANNELS >= 8 && !seq) wr_s = 8'b1111_0000;
         end
         default: begin
            // two cylinders, and counts with no layout of their own
            wr_p = 8'b0000_0011;
            wr_s = 8'b0000_1100;
         end
      endcase
   end

   assign p_sum = {1'b0, pri_ff} + {1'b0, open_ff};
   assign s_sum = {1'b0, sec_ff} + {1'b0, open_ff};
   assign p16   = p_sum[PW_W] ? MAX_PW : p_sum[PW_W-1:0];
   assign s16   = (sec_ff == '0) ? '0 : (s_sum[PW_W] ? MAX_PW : s_sum[PW_W-1:0]);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      desired_in   = desired_ff;
      limit_in     = limit_ff;
      split_in     = split_ff;
      staged_in    = staged_ff;
      active_in    = active_ff;
      scaled_in    = scaled_ff;
      pri_in       = pri_ff;
      sec_in       = sec_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      chan_in      = chan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               desired_in = req_desired;
               limit_in   = req_limit;
               split_in   = (req_split > PCT) ? PCT : req_split;
               staged_in  = req_stage;
               active_in  = 1'b0;
               pri_in     = req_desired - open_ff;
               sec_in     = '0;
               if (req_stage && (mode_ff == MODE_TABLE || mode_ff == MODE_AUTO)) begin
                  op_in    = OP_SCALED;
                  a_in     = OPA_W'(req_desired - open_ff);
                  b_in     = pmult_ff;
                  d_in     = PCT_DIV;
                  acc_in   = '0;
                  cnt_in   = CNT_W'(OPB_W - 1);
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            acc_in = {acc_ff[ACC_W-2:0], 1'b0} + (b_ff[OPB_W-1] ? ACC_W'(a_ff) : '0);
            b_in   = {b_ff[OPB_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = CNT_W'(ACC_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            acc_in = quot;
            rem_in = qbit ? OPB_W'(trial - {1'b0, d_ff}) : trial[OPB_W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // operation finished; chain the next one or wrap up
               acc_in   = '0;
               cnt_in   = CNT_W'(OPB_W - 1);
               d_in     = PCT_DIV;
               state_in = ST_MUL;
               unique case (op_ff)
                  OP_SCALED: begin
                     scaled_in = quot[OPA_W-1:0];
                     if (mode_ff == MODE_TABLE) begin
                        op_in = OP_SEC_SCALED;
                        a_in  = OPA_W'(pri_ff);
                        b_in  = smult_ff;
                     end else if (quot[OPA_W-1:0] > OPA_W'(limit_ff)) begin
                        active_in = 1'b1;
                        pri_in    = limit_ff;
                        if (pmult_ff == '0) begin
                           sec_in   = MAX_PW;
                           state_in = ST_DONE;
                        end else begin
                           op_in = OP_SEC_AUTO;
                           a_in  = extra;
                           b_in  = smult_ff;
                           d_in  = pmult_ff;
                        end
                     end else begin
                        pri_in   = quot_sat;
                        state_in = ST_DONE;
                     end
                  end
                  OP_SEC_SCALED: begin
                     op_in = OP_SEC_TABLE;
                     a_in  = quot[OPA_W-1:0];
                     b_in  = OPB_W'(split_ff);
                  end
                  OP_SEC_TABLE: begin
                     sec_in    = quot_sat;
                     active_in = (split_ff != '0);
                     op_in     = OP_PRI_TABLE;
                     a_in      = scaled_ff;
                     b_in      = OPB_W'(PCT - split_ff);
                  end
                  OP_PRI_TABLE: begin
                     pri_in   = quot_sat;
                     state_in = ST_DONE;
                  end
                  OP_SEC_AUTO: begin
                     sec_in   = quot_sat;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (!staged_ff) begin
                     chan_in[i] = (CYL_W'(i) < outcnt_ff) ? desired_ff : '0;
                  end else if (wr_p[i]) begin
                     chan_in[i] = p16;
                  end else if (wr_s[i]) begin
                     chan_in[i] = s16;
                  end
               end
               rsp_data_in = '0;
               for (int i = 0; i < CHANNELS; i++) begin
                  rsp_data_in[PW_W*i +: PW_W] = chan_in[i];
               end
               rsp_data_in[ACTIVE_BIT] = staged_ff && active_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SCALED;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) chan_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         chan_ff      <= chan_in;
      end
      desired_ff  <= desired_in;
      limit_ff    <= limit_in;
      split_ff    <= split_in;
      staged_ff   <= staged_in;
      active_ff   <= active_in;
      scaled_ff   <= scaled_in;
      pri_ff      <= pri_in;
      sec_ff      <= sec_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      d_ff        <= d_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OFF;
         open_ff   <= '0;
         pmult_ff  <= 16'd100;
         smult_ff  <= 16'd100;
         cyl_ff    <= 4'd4;
         layout_ff <= '0;
         tb_ff     <= 1'b0;
         outcnt_ff <= 4'd4;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_STAGING_MODE:    mode_ff   <= csr_data[MODE_W-1:0];
            REG_OPEN_TIME:       open_ff   <= csr_data;
            REG_PRIMARY_MULT:    pmult_ff  <= csr_data;
            REG_SECONDARY_MULT:  smult_ff  <= csr_data;
            REG_CYLINDER_COUNT:  cyl_ff    <= csr_data[CYL_W-1:0];
            REG_INJECTOR_LAYOUT: layout_ff <= csr_data[LAYOUT_W-1:0];
            REG_THROTTLE_BODY:   tb_ff     <= csr_data[0];
            REG_OUTPUT_COUNT:    outcnt_ff <= csr_data[CYL_W-1:0];
            default: ;
         endcase
      end
   end

   // a new item shows up only after the wrap-up state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside wrap-up");

   // only the table and overflow modes can light the secondaries
   a_active_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_tready) && rsp_data_in[ACTIVE_BIT])
      |-> (mode_ff == MODE_TABLE || mode_ff == MODE_AUTO))
      else $error("staging flag in a mode without split");

   // divider partial remainder always below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && d_ff != '0) |-> (rem_ff < d_ff))
      else $error("divider remainder out of range");

   // channels beyond CHANNELS read zero
   a_hi_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[127:0] & HI_MASK) == '0))
      else $error("missing channel carries a width");

endmodule
